// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the downmix ring buffer.
// Depends on nothing; NO_ASSERTIONS removes every check at compile time.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is asserted.
`define DAJF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define DAJF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DAJF_ASSERT(label, clk, rst_n, prop, msg)
`define DAJF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/core/dajf_pkg.sv =====
// Package of the stereo downmix ring buffer: sizes, mix weights, action codes and types.
// Depends on nothing; used by dajf_mix and downmix_audio_jitter_fifo_top.
`timescale 1ns / 1ps

package dajf_pkg;

    // Ring and run sizes.
    localparam int RING_FRAMES = 2048;
    localparam int RUN_FRAMES  = 32;
    localparam int IDX_W       = $clog2(RING_FRAMES);
    localparam int FILL_W      = $clog2(RING_FRAMES + 1);
    localparam int RUN_CNT_W   = (RUN_FRAMES > 1) ? $clog2(RUN_FRAMES) : 1;

    // Field widths.
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 4;
    localparam int SAMPLE_W = 16;
    localparam int TOTAL_W  = 32;

    // Action codes; the fourth code is ignored.
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [COUNT_W-1:0] MAX_CHANNELS = 4'd6;

    // Mix weights in units of 1/10000.
    localparam int W_FRONT  = 10000;
    localparam int W_CENTER = 7071;
    localparam int W_LFE    = 2500;
    localparam int W_SURR   = 5000;

    // Accumulator and reciprocal divider sizes.
    localparam int ACC_W       = 32;
    localparam int MAG_W       = 29;
    localparam int RECIP_SHIFT = 43;
    localparam int RECIP_W     = 30;
    localparam int QPROD_W     = MAG_W + RECIP_W;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + 64'(W_FRONT) - 64'd1) / 64'(W_FRONT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    // Accumulator limits beyond which the truncated quotient saturates.
    localparam logic signed [ACC_W-1:0] SAT_HI_ACC = ACC_W'(32768 * W_FRONT);
    localparam logic signed [ACC_W-1:0] SAT_LO_ACC = ACC_W'(-32769 * W_FRONT);

    // Samples and controls of one push.
    typedef struct packed {
        logic                       rate;
        logic [COUNT_W-1:0]         count;
        logic signed [SAMPLE_W-1:0] fl;
        logic signed [SAMPLE_W-1:0] fr;
        logic signed [SAMPLE_W-1:0] ctr;
        logic signed [SAMPLE_W-1:0] lfe;
        logic signed [SAMPLE_W-1:0] sl;
        logic signed [SAMPLE_W-1:0] sr;
    } mix_in_t;

    // Stored frame: left in the low half, right in the high half.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } frame_t;

    // Status of the mix pipeline.
    typedef struct packed {
        logic frame_valid;
        logic busy;
    } mix_stat_t;

    // One result beat.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
        logic                       underrun;
        logic [FILL_W-1:0]          fill;
        logic [TOTAL_W-1:0]         total;
    } beat_t;

    // Next ring position with wrap.
    function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_FRAMES - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

// ===== rtl/core/dajf_mix.sv =====
// Five-stage downmix pipeline: weights, sums, saturation, reciprocal divide, pack.
// Depends on dajf_pkg.
`timescale 1ns / 1ps

module dajf_mix (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  dajf_pkg::mix_in_t  in_data,
    output dajf_pkg::mix_stat_t stat,
    output dajf_pkg::frame_t   frame_out
);
    import dajf_pkg::*;

    localparam logic signed [ACC_W-1:0] K_FRONT  = ACC_W'(W_FRONT);
    localparam logic signed [ACC_W-1:0] K_CENTER = ACC_W'(W_CENTER);
    localparam logic signed [ACC_W-1:0] K_LFE    = ACC_W'(W_LFE);
    localparam logic signed [ACC_W-1:0] K_SURR   = ACC_W'(W_SURR);

    logic [4:0] vld_reg;

    logic [COUNT_W-1:0]         n_eff;
    logic                       active;
    logic signed [SAMPLE_W-1:0] s_front [2];
    logic signed [SAMPLE_W-1:0] s_surr  [2];
    logic signed [SAMPLE_W-1:0] s_ctr;
    logic signed [SAMPLE_W-1:0] s_lfe;

    logic signed [ACC_W-1:0] front_reg [2];
    logic signed [ACC_W-1:0] surr_reg  [2];
    logic signed [ACC_W-1:0] ctr_reg;
    logic signed [ACC_W-1:0] lfe_reg;
    logic signed [ACC_W-1:0] acc_reg   [2];
    logic                    neg3_reg  [2];
    logic                    hi3_reg   [2];
    logic                    lo3_reg   [2];
    logic [MAG_W-1:0]        mag_reg   [2];
    logic                    neg4_reg  [2];
    logic                    hi4_reg   [2];
    logic                    lo4_reg   [2];
    logic [QPROD_W-1:0]      qprod_reg [2];
    frame_t                  frame_reg;

    logic [SAMPLE_W-1:0]     quot [2];
    logic [SAMPLE_W-1:0]     res  [2];

    // Channel selection: missing channels count as zero, one channel feeds both sides.
    always_comb begin
        n_eff  = (in_data.count > MAX_CHANNELS) ? MAX_CHANNELS : in_data.count;
        active = in_data.rate && (in_data.count != '0);
        s_front[0] = active ? in_data.fl : '0;
        s_front[1] = active ? ((n_eff > 4'd1) ? in_data.fr : in_data.fl) : '0;
        s_ctr      = (active && (n_eff > 4'd2)) ? in_data.ctr : '0;
        s_lfe      = (active && (n_eff > 4'd3)) ? in_data.lfe : '0;
        s_surr[0]  = (active && (n_eff > 4'd4)) ? in_data.sl : '0;
        s_surr[1]  = (active && (n_eff > 4'd5)) ? in_data.sr : '0;
    end

    // Beat valid through the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Divider output: quotient magnitude, then sign and saturation.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            quot[i] = qprod_reg[i][RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
            if (hi4_reg[i]) begin
                res[i] = 16'h7FFF;
            end else if (lo4_reg[i]) begin
                res[i] = 16'h8000;
            end else begin
                res[i] = neg4_reg[i] ? (16'd0 - quot[i]) : quot[i];
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge aclk) begin
        // Weighted products.
        for (int i = 0; i < 2; i++) begin
            front_reg[i] <= ACC_W'(s_front[i]) * K_FRONT;
            surr_reg[i]  <= ACC_W'(s_surr[i]) * K_SURR;
        end
        ctr_reg <= ACC_W'(s_ctr) * K_CENTER;
        lfe_reg <= ACC_W'(s_lfe) * K_LFE;
        // Sums, saturation test and magnitude, reciprocal multiply.
        for (int i = 0; i < 2; i++) begin
            acc_reg[i]   <= front_reg[i] + ctr_reg + lfe_reg + surr_reg[i];
            neg3_reg[i]  <= acc_reg[i] < 0;
            hi3_reg[i]   <= acc_reg[i] >= SAT_HI_ACC;
            lo3_reg[i]   <= acc_reg[i] <= SAT_LO_ACC;
            mag_reg[i]   <= MAG_W'((acc_reg[i] < 0) ? -acc_reg[i] : acc_reg[i]);
            neg4_reg[i]  <= neg3_reg[i];
            hi4_reg[i]   <= hi3_reg[i];
            lo4_reg[i]   <= lo3_reg[i];
            qprod_reg[i] <= QPROD_W'(mag_reg[i]) * QPROD_W'(RECIP);
        end
        // Packed frame.
        frame_reg.left  <= res[0];
        frame_reg.right <= res[1];
    end

    assign stat.frame_valid = vld_reg[4];
    assign stat.busy        = |vld_reg;
    assign frame_out        = frame_reg;

endmodule

// ===== rtl/core/downmix_audio_jitter_fifo_top.sv =====
// Top level of the stereo downmix ring buffer: ring memory, read sequencer, output queue.
// Depends on dajf_pkg, dajf_mix and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// The input channel (s_valid, s_ready) takes one action per beat: push a frame,
// read a run, or clear the ring. The result channel (m_valid, m_ready) carries
// the frames of a run, one per beat, with last on the final beat.
// A push is taken every cycle while no run is being issued; its frame runs through
// the five-stage mix pipeline and is then written to the ring memory.
// A read or clear waits until that pipeline has drained. A read then enters
// the run state and issues one ring memory read per cycle while the output
// queue has room. The first frame passes the memory read register and the
// output queue, and frames follow one per cycle while m_ready
// stays high. No new action is taken until the run has been issued.
// An underrun run needs no memory reads and keeps the same timing.
// Reset empties the ring, clears the underrun count and drops queued frames;
// the ring memory itself is not cleared, since only written entries are read.
// When the receiver stalls, a two-entry output queue and the one read in
// flight hold the run, and memory reads pause until the queue has room.

module downmix_audio_jitter_fifo_top (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [dajf_pkg::ACTION_W-1:0]            s_action,
    input  logic                                     s_rate_matches,
    input  logic [dajf_pkg::COUNT_W-1:0]             s_channel_count,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0]     s_front_left,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0]     s_front_right,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0]     s_center,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0]     s_low_freq,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0]     s_surround_left,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0]     s_surround_right,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [dajf_pkg::SAMPLE_W-1:0]     m_left_out,
    output logic signed [dajf_pkg::SAMPLE_W-1:0]     m_right_out,
    output logic                                     m_last,
    output logic                                     m_underrun,
    output logic [dajf_pkg::FILL_W-1:0]              m_frames_buffered,
    output logic [dajf_pkg::TOTAL_W-1:0]             m_underrun_total
);
    import dajf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Control state.
    logic                 state_reg,    state_next;
    logic [RUN_CNT_W-1:0] run_cnt_reg,  run_cnt_next;
    logic                 run_under_reg, run_under_next;
    logic [IDX_W-1:0]     rd_idx_reg,   rd_idx_next;
    logic [IDX_W-1:0]     wr_idx_reg,   wr_idx_next;
    logic [FILL_W-1:0]    fill_reg,     fill_next;
    logic [TOTAL_W-1:0]   total_reg,    total_next;
    logic                 issue_vld_reg;
    logic [1:0]           fifo_cnt_reg, fifo_cnt_next;
    logic                 fifo_wp_reg;
    logic                 fifo_rp_reg;

    // Payload state.
    frame_t               mem [RING_FRAMES];
    frame_t               rd_data_reg;
    beat_t                issue_beat_reg;
    beat_t                fifo_reg [2];

    mix_in_t              mix_in;
    mix_stat_t            mix_stat;
    frame_t               mix_frame;

    logic                 in_acc;
    logic                 push_acc;
    logic                 read_acc;
    logic                 clear_acc;
    logic                 pop;
    logic                 issue;
    logic [1:0]           occ;
    beat_t                issue_beat;
    beat_t                push_beat;
    beat_t                head;

    // Input handshake: reads and clears wait for pending pushes to land.
    assign s_ready   = (state_reg == ST_IDLE) &&
                       (!((s_action == ACT_READ) || (s_action == ACT_CLEAR)) || !mix_stat.busy);
    assign in_acc    = s_valid && s_ready;
    assign push_acc  = in_acc && (s_action == ACT_PUSH);
    assign read_acc  = in_acc && (s_action == ACT_READ);
    assign clear_acc = in_acc && (s_action == ACT_CLEAR);

    // Downmix pipeline.
    assign mix_in.rate  = s_rate_matches;
    assign mix_in.count = s_channel_count;
    assign mix_in.fl    = s_front_left;
    assign mix_in.fr    = s_front_right;
    assign mix_in.ctr   = s_center;
    assign mix_in.lfe   = s_low_freq;
    assign mix_in.sl    = s_surround_left;
    assign mix_in.sr    = s_surround_right;

    dajf_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_acc),
        .in_data   (mix_in),
        .stat      (mix_stat),
        .frame_out (mix_frame)
    );

    // Memory reads are issued while the queue plus the read in flight has room.
    assign pop   = m_valid && m_ready;
    assign occ   = fifo_cnt_reg + 2'(issue_vld_reg);
    assign issue = (state_reg == ST_RUN) && ((occ < 2'd2) || pop);

    always_comb begin
        issue_beat.left     = '0;
        issue_beat.right    = '0;
        issue_beat.last     = (run_cnt_reg == RUN_CNT_W'(RUN_FRAMES - 1));
        issue_beat.underrun = run_under_reg;
        issue_beat.fill     = run_under_reg ? fill_reg : fill_reg - 1'b1;
        issue_beat.total    = total_reg;
    end

    // Ring pointers, fill count, underrun count and run sequencer.
    always_comb begin
        state_next     = state_reg;
        run_cnt_next   = run_cnt_reg;
        run_under_next = run_under_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;

        priority if (clear_acc) begin
            rd_idx_next = '0;
            wr_idx_next = '0;
            fill_next   = '0;
        end else if (mix_stat.frame_valid) begin
            // A full ring drops its oldest frame to make room.
            if (fill_reg == FILL_W'(RING_FRAMES)) begin
                rd_idx_next = idx_wrap(rd_idx_reg);
            end else begin
                fill_next = fill_reg + 1'b1;
            end
            wr_idx_next = idx_wrap(wr_idx_reg);
        end else if (issue && !run_under_reg) begin
            rd_idx_next = idx_wrap(rd_idx_reg);
            fill_next   = fill_reg - 1'b1;
        end

        if (read_acc) begin
            state_next     = ST_RUN;
            run_cnt_next   = '0;
            run_under_next = fill_reg < FILL_W'(RUN_FRAMES);
            if ((fill_reg < FILL_W'(RUN_FRAMES)) && (total_reg != '1)) begin
                total_next = total_reg + 1'b1;
            end
        end else if (issue) begin
            run_cnt_next = run_cnt_reg + 1'b1;
            if (issue_beat.last) begin
                state_next = ST_IDLE;
            end
        end
    end

    // Output queue count.
    always_comb begin
        fifo_cnt_next = fifo_cnt_reg + 2'(issue_vld_reg) - 2'(pop);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            run_cnt_reg   <= '0;
            run_under_reg <= 1'b0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            issue_vld_reg <= 1'b0;
            fifo_cnt_reg  <= '0;
            fifo_wp_reg   <= 1'b0;
            fifo_rp_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_cnt_reg   <= run_cnt_next;
            run_under_reg <= run_under_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            issue_vld_reg <= issue;
            fifo_cnt_reg  <= fifo_cnt_next;
            if (issue_vld_reg) begin
                fifo_wp_reg <= !fifo_wp_reg;
            end
            if (pop) begin
                fifo_rp_reg <= !fifo_rp_reg;
            end
        end
    end

    // Ring memory: one write port for landed pushes, one registered read port.
    always_ff @(posedge aclk) begin
        if (mix_stat.frame_valid) begin
            mem[wr_idx_reg] <= mix_frame;
        end
        if (issue && !run_under_reg) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // Beat in flight joins its memory data on entry to the queue.
    always_comb begin
        push_beat = issue_beat_reg;
        if (!issue_beat_reg.underrun) begin
            push_beat.left  = rd_data_reg.left;
            push_beat.right = rd_data_reg.right;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            issue_beat_reg <= issue_beat;
        end
        if (issue_vld_reg) begin
            fifo_reg[fifo_wp_reg] <= push_beat;
        end
    end

    // Result channel from the queue head.
    assign head              = fifo_reg[fifo_rp_reg];
    assign m_valid           = (fifo_cnt_reg != 2'd0);
    assign m_left_out        = head.left;
    assign m_right_out       = head.right;
    assign m_last            = head.last;
    assign m_underrun        = head.underrun;
    assign m_frames_buffered = head.fill;
    assign m_underrun_total  = head.total;

    // Checks on the queue credit, the interlock and the underrun count.
    `DAJF_ASSERT(a_queue_room, aclk, aresetn, (fifo_cnt_reg + 2'(issue_vld_reg)) <= 2'd2, "output queue overfilled")
    `DAJF_ASSERT(a_read_after_mix, aclk, aresetn, issue |-> !mix_stat.busy, "memory read while a push is pending")
    `DAJF_ASSERT(a_write_idle, aclk, aresetn, mix_stat.frame_valid |-> (state_reg == ST_IDLE), "frame landed during a run")
    `DAJF_ASSERT(a_total_mono, aclk, aresetn, 1'b1 |=> (total_reg >= $past(total_reg)), "underrun count went down")

endmodule

// ===== test/downmix_fifo_checker.sv =====
// Checker for the stereo downmix ring buffer: watches both channels, models the ring and
// compares every result beat. Depends on dajf_pkg; instantiated by tb_downmix_audio_jitter_fifo_top.
`timescale 1ns / 1ps

module downmix_fifo_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [dajf_pkg::ACTION_W-1:0]        s_action,
    input  logic                                 s_rate_matches,
    input  logic [dajf_pkg::COUNT_W-1:0]         s_channel_count,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0] s_front_left,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0] s_front_right,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0] s_center,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0] s_low_freq,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0] s_surround_left,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0] s_surround_right,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0] m_left_out,
    input  logic signed [dajf_pkg::SAMPLE_W-1:0] m_right_out,
    input  logic                                 m_last,
    input  logic                                 m_underrun,
    input  logic [dajf_pkg::FILL_W-1:0]          m_frames_buffered,
    input  logic [dajf_pkg::TOTAL_W-1:0]         m_underrun_total,
    output int                                   mismatch_count,
    output int                                   pending_beats,
    output int                                   beats_checked,
    output int                                   underrun_runs
);
    import dajf_pkg::*;

    localparam longint SAMPLE_HI = 32767;
    localparam longint SAMPLE_LO = -32768;
    localparam int     REPORT_MAX = 10;

    // Model of the ring: frame memory, positions, fill level and underrun count.
    frame_t             ring_mem [RING_FRAMES];
    int                 rd_pos;
    int                 wr_pos;
    int                 held;
    logic [TOTAL_W-1:0] underruns_seen;
    beat_t              frames_due [$];

    // Truncate the scaled sum toward zero and clamp it to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] clip_mix(input longint acc);
        longint q;
        q = acc / W_FRONT;
        if (q > SAMPLE_HI) q = SAMPLE_HI;
        if (q < SAMPLE_LO) q = SAMPLE_LO;
        return q[SAMPLE_W-1:0];
    endfunction

    // Stereo frame that one push puts into the ring.
    function automatic frame_t mix_frame(input mix_in_t x);
        frame_t f;
        longint lft;
        longint rgt;
        longint shared;
        int     n;
        f = '0;
        n = (x.count > MAX_CHANNELS) ? int'(MAX_CHANNELS) : int'(x.count);
        if (!x.rate || n == 0) return f;
        lft = longint'($signed(x.fl)) * W_FRONT;
        rgt = (n > 1) ? longint'($signed(x.fr)) * W_FRONT : lft;
        if (n > 2) begin
            shared = longint'($signed(x.ctr)) * W_CENTER;
            lft += shared;
            rgt += shared;
        end
        if (n > 3) begin
            shared = longint'($signed(x.lfe)) * W_LFE;
            lft += shared;
            rgt += shared;
        end
        if (n > 4) lft += longint'($signed(x.sl)) * W_SURR;
        if (n > 5) rgt += longint'($signed(x.sr)) * W_SURR;
        f.left  = clip_mix(lft);
        f.right = clip_mix(rgt);
        return f;
    endfunction

    // Queue the beats of one read: stored frames, or silence when too few are held.
    task automatic queue_run();
        beat_t  b;
        frame_t f;
        bit     short_run;
        short_run = (held < RUN_FRAMES);
        if (short_run) begin
            if (underruns_seen != '1) underruns_seen++;
            underrun_runs++;
        end
        for (int k = 0; k < RUN_FRAMES; k++) begin
            f = '0;
            if (!short_run) begin
                f = ring_mem[rd_pos];
                rd_pos = (rd_pos == RING_FRAMES - 1) ? 0 : rd_pos + 1;
                held--;
            end
            b.left     = f.left;
            b.right    = f.right;
            b.last     = (k == RUN_FRAMES - 1);
            b.underrun = short_run;
            b.fill     = FILL_W'(held);
            b.total    = underruns_seen;
            frames_due.push_back(b);
        end
    endtask

    // Apply each input beat to the model and compare each result beat.
    always @(posedge aclk) begin : track
        mix_in_t x;
        beat_t   got;
        beat_t   want;
        string   diffs;
        if (!aresetn) begin
            rd_pos         = 0;
            wr_pos         = 0;
            held           = 0;
            underruns_seen = '0;
            frames_due.delete();
            mismatch_count = 0;
            beats_checked  = 0;
            underrun_runs  = 0;
        end else begin
            if (s_valid && s_ready) begin
                x.rate  = s_rate_matches;
                x.count = s_channel_count;
                x.fl    = s_front_left;
                x.fr    = s_front_right;
                x.ctr   = s_center;
                x.lfe   = s_low_freq;
                x.sl    = s_surround_left;
                x.sr    = s_surround_right;
                case (s_action)
                    ACT_PUSH: begin
                        // A full ring drops its oldest frame first.
                        if (held >= RING_FRAMES) begin
                            rd_pos = (rd_pos == RING_FRAMES - 1) ? 0 : rd_pos + 1;
                            held--;
                        end
                        ring_mem[wr_pos] = mix_frame(x);
                        wr_pos = (wr_pos == RING_FRAMES - 1) ? 0 : wr_pos + 1;
                        held++;
                    end
                    ACT_READ: begin
                        queue_run();
                    end
                    ACT_CLEAR: begin
                        rd_pos = 0;
                        wr_pos = 0;
                        held   = 0;
                    end
                    default: begin
                        // The spare code leaves everything as it is.
                    end
                endcase
            end

            if (m_valid && m_ready) begin
                got.left     = m_left_out;
                got.right    = m_right_out;
                got.last     = m_last;
                got.underrun = m_underrun;
                got.fill     = m_frames_buffered;
                got.total    = m_underrun_total;
                beats_checked++;
                if (frames_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected output beat left=%0d right=%0d last=%0b",
                                 $realtime, $signed(got.left), $signed(got.right), got.last);
                end else begin
                    want  = frames_due.pop_front();
                    diffs = "";
                    if (got.left !== want.left)         diffs = {diffs, " left"};
                    if (got.right !== want.right)       diffs = {diffs, " right"};
                    if (got.last !== want.last)         diffs = {diffs, " last"};
                    if (got.underrun !== want.underrun) diffs = {diffs, " underrun"};
                    if (got.fill !== want.fill)         diffs = {diffs, " frames_buffered"};
                    if (got.total !== want.total)       diffs = {diffs, " underrun_total"};
                    if (diffs != "") begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("%0t: output beat differs in%s", $realtime, diffs);
                            $display("    expected L=%0d R=%0d last=%0b und=%0b fill=%0d tot=%0d",
                                     $signed(want.left), $signed(want.right), want.last,
                                     want.underrun, want.fill, want.total);
                            $display("    actual   L=%0d R=%0d last=%0b und=%0b fill=%0d tot=%0d",
                                     $signed(got.left), $signed(got.right), got.last,
                                     got.underrun, got.fill, got.total);
                        end
                    end
                end
            end
        end
        pending_beats = frames_due.size();
    end

endmodule

// ===== test/tb_downmix_audio_jitter_fifo_top.sv =====
// Testbench top for the stereo downmix ring buffer: clock, reset, stimulus, receiver stalls
// and verdict. Depends on dajf_pkg, downmix_audio_jitter_fifo_top and downmix_fifo_checker.
`timescale 1ns / 1ps

module tb_downmix_audio_jitter_fifo_top;
    import dajf_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
    localparam int RANDOM_ITEMS = 340;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 16;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [ACTION_W-1:0]        s_action = ACT_PUSH;
    logic                       s_rate_matches = 1'b0;
    logic [COUNT_W-1:0]         s_channel_count = '0;
    logic signed [SAMPLE_W-1:0] s_front_left = '0;
    logic signed [SAMPLE_W-1:0] s_front_right = '0;
    logic signed [SAMPLE_W-1:0] s_center = '0;
    logic signed [SAMPLE_W-1:0] s_low_freq = '0;
    logic signed [SAMPLE_W-1:0] s_surround_left = '0;
    logic signed [SAMPLE_W-1:0] s_surround_right = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_left_out;
    logic signed [SAMPLE_W-1:0] m_right_out;
    logic                       m_last;
    logic                       m_underrun;
    logic [FILL_W-1:0]          m_frames_buffered;
    logic [TOTAL_W-1:0]         m_underrun_total;

    int mismatch_count;
    int pending_beats;
    int beats_checked;
    int underrun_runs;
    int idle_cycles = 0;
    int burst_left = 0;
    int n_push = 0;
    int n_read = 0;
    int n_clear = 0;
    bit hold_req = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    downmix_audio_jitter_fifo_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_rate_matches    (s_rate_matches),
        .s_channel_count   (s_channel_count),
        .s_front_left      (s_front_left),
        .s_front_right     (s_front_right),
        .s_center          (s_center),
        .s_low_freq        (s_low_freq),
        .s_surround_left   (s_surround_left),
        .s_surround_right  (s_surround_right),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_out        (m_left_out),
        .m_right_out       (m_right_out),
        .m_last            (m_last),
        .m_underrun        (m_underrun),
        .m_frames_buffered (m_frames_buffered),
        .m_underrun_total  (m_underrun_total)
    );

    downmix_fifo_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_rate_matches    (s_rate_matches),
        .s_channel_count   (s_channel_count),
        .s_front_left      (s_front_left),
        .s_front_right     (s_front_right),
        .s_center          (s_center),
        .s_low_freq        (s_low_freq),
        .s_surround_left   (s_surround_left),
        .s_surround_right  (s_surround_right),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_out        (m_left_out),
        .m_right_out       (m_right_out),
        .m_last            (m_last),
        .m_underrun        (m_underrun),
        .m_frames_buffered (m_frames_buffered),
        .m_underrun_total  (m_underrun_total),
        .mismatch_count    (mismatch_count),
        .pending_beats     (pending_beats),
        .beats_checked     (beats_checked),
        .underrun_runs     (underrun_runs)
    );

    // Samples lean toward full scale and tiny values so saturation and truncation get hit.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return SAMPLE_W'($urandom_range(0, 8) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic mix_in_t mix_of(input logic rate, input int count,
                                       input logic signed [SAMPLE_W-1:0] fl, fr, ctr,
                                       input logic signed [SAMPLE_W-1:0] lfe, sl, sr);
        mix_in_t x;
        x.rate  = rate;
        x.count = COUNT_W'(count);
        x.fl    = fl;
        x.fr    = fr;
        x.ctr   = ctr;
        x.lfe   = lfe;
        x.sl    = sl;
        x.sr    = sr;
        return x;
    endfunction

    function automatic mix_in_t rand_mix();
        int count;
        count = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
        return mix_of($urandom_range(0, 9) != 0, count, rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endfunction

    // Offer one beat and hold it until taken; the sender idles between bursts.
    task automatic send_beat(input logic [ACTION_W-1:0] act, input mix_in_t x);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_action         <= act;
        s_rate_matches   <= x.rate;
        s_channel_count  <= x.count;
        s_front_left     <= x.fl;
        s_front_right    <= x.fr;
        s_center         <= x.ctr;
        s_low_freq       <= x.lfe;
        s_surround_left  <= x.sl;
        s_surround_right <= x.sr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (act)
            ACT_PUSH:  n_push++;
            ACT_READ:  n_read++;
            ACT_CLEAR: n_clear++;
            default: ;
        endcase
    endtask

    // Stop offering beats until every expected frame has come out.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_beats != 0) @(negedge aclk);
    endtask

    // Receiver: randomly chosen stall patterns, plus one long hold.
    initial begin : receiver
        int hold_left;
        int mode;
        int mode_left;
        int phase;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            phase = (phase == 4) ? 0 : phase + 1;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (phase < 3);
                endcase
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int random_items;
        int round_no;
        int n;
        random_items = 0;
        round_no     = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: read of an empty ring, spare code, clear, and one push for each mixing corner.
        send_beat(ACT_READ, rand_mix());
        send_beat(ACT_SPARE, rand_mix());
        send_beat(ACT_CLEAR, rand_mix());
        send_beat(ACT_PUSH, mix_of(1'b1, 0, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        send_beat(ACT_PUSH, mix_of(1'b1, 1, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        send_beat(ACT_PUSH, mix_of(1'b1, 2, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX));
        send_beat(ACT_PUSH, mix_of(1'b1, 3, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN));
        send_beat(ACT_PUSH, mix_of(1'b1, 4, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX));
        send_beat(ACT_PUSH, mix_of(1'b1, 5, 16'sd100, -16'sd100, '0, '0, S_MIN, S_MAX));
        send_beat(ACT_PUSH, mix_of(1'b1, 6, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
        // Small negative sums must truncate toward zero, not round down.
        send_beat(ACT_PUSH, mix_of(1'b1, 6, '0, '0, -16'sd1, 16'sd1, -16'sd1, 16'sd1));
        send_beat(ACT_PUSH, mix_of(1'b1, 6, -16'sd3, 16'sd3, -16'sd1, '0, '0, '0));
        // Counts above six behave as six.
        send_beat(ACT_PUSH, mix_of(1'b1, 7, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
        send_beat(ACT_PUSH, mix_of(1'b1, 8, rand_sample(), rand_sample(), rand_sample(),
                                   rand_sample(), rand_sample(), rand_sample()));
        send_beat(ACT_PUSH, mix_of(1'b1, 15, 16'sh5555, 16'shAAAA, 16'sh5555,
                                   16'shAAAA, 16'sh5555, 16'shAAAA));
        send_beat(ACT_PUSH, mix_of(1'b1, 6, 16'shAAAA, 16'sh5555, 16'shAAAA,
                                   16'sh5555, 16'shAAAA, 16'sh5555));
        // Rate mismatch pushes silence whatever the samples are.
        send_beat(ACT_PUSH, mix_of(1'b0, 6, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
        send_beat(ACT_READ, rand_mix());

        // Random rounds: a burst of pushes, then reads, with clears and noise mixed in.
        while (random_items < RANDOM_ITEMS) begin
            round_no++;
            if (round_no == 3) hold_req = 1'b1;
            n = $urandom_range(20, 60);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0) send_beat(ACT_SPARE, rand_mix());
                send_beat(ACT_PUSH, rand_mix());
                random_items++;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_beat(ACT_CLEAR, rand_mix());
                random_items++;
            end
            n = $urandom_range(1, 3);
            repeat (n) begin
                send_beat(ACT_READ, rand_mix());
                random_items++;
            end
            if (round_no == 2) drain_results();
        end
        drain_results();

        // A clear keeps the underrun count; the next read is silence again.
        repeat (40) send_beat(ACT_PUSH, rand_mix());
        send_beat(ACT_CLEAR, rand_mix());
        send_beat(ACT_READ, rand_mix());

        drain_results();
        repeat (SETTLE) @(negedge aclk);

        $display("Sent %0d pushes, %0d reads and %0d clears; checked %0d frames, %0d silent runs.",
                 n_push, n_read, n_clear, beats_checked, underrun_runs);
        $display("Run covered mixing corners, silent runs, clears and a long output stall.");
        if (mismatch_count == 0 && pending_beats == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== downmix_audio_jitter_fifo_top.f =====
+incdir+rtl/core
rtl/core/dajf_pkg.sv
rtl/core/dajf_mix.sv
rtl/core/downmix_audio_jitter_fifo_top.sv
test/downmix_fifo_checker.sv
test/tb_downmix_audio_jitter_fifo_top.sv
